// File: rtl/cfm_pkg.sv
// ----------------------------------------------------------------------------
// cfm_pkg: shared types and constants
// Field widths, register indexes and pipeline types of the circle feather mask.
// ----------------------------------------------------------------------------
package cfm_pkg;

   localparam int COORD_W    = 21;
   localparam int RADIUS_W   = 20;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int D2_W       = 2 * DIFF_W;
   localparam int SQ_W       = 2 * RADIUS_W;
   localparam int HALF_W     = SQ_W / 2;
   localparam int WIDE_W     = 2 * SQ_W;
   localparam int REM_W      = WIDE_W + 1;
   localparam int Q_W        = 16;
   localparam int MASK_W     = Q_W + 1;
   localparam int DIV_STAGES = Q_W;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = COORD_W;

   localparam logic [MASK_W-1:0] MASK_ONE = MASK_W'(1) << Q_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_RADIUS = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_RADIUS = 8'd3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [RADIUS_W-1:0]       radius_type;
   typedef logic [MASK_W-1:0]         mask_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]     csr_data_type;

   // region of the squared distance, decided before the division
   typedef struct packed {
      logic core;
      logic band;
   } tag_type;

   // load enables of the two squarer stages
   typedef struct packed {
      logic pp;
      logic sum;
   } sqr_en_type;

endpackage

// File: rtl/cfm_if.sv
// ----------------------------------------------------------------------------
// cfm_if: channel interfaces
// Valid/ready channels for pixel requests, mask responses and register writes.
// ----------------------------------------------------------------------------
interface cfm_req_if;
   logic              valid;
   logic              ready;
   cfm_pkg::coord_type pixel_x;
   cfm_pkg::coord_type pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface cfm_rsp_if;
   logic              valid;
   logic              ready;
   cfm_pkg::mask_type mask_value;

   modport source (output valid, output mask_value, input ready);
   modport sink   (input valid, input mask_value, output ready);
endinterface

interface cfm_csr_if;
   logic                  valid;
   logic                  ready;
   cfm_pkg::csr_idx_type  index;
   cfm_pkg::csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/cfm_sqr.sv
// ----------------------------------------------------------------------------
// cfm_sqr: two-stage squarer
// Squares a 40-bit value from three 20x20 partial products, then one add.
// ----------------------------------------------------------------------------
module cfm_sqr (
   input  logic                          clock,
   input  cfm_pkg::sqr_en_type           en,
   input  logic [cfm_pkg::SQ_W-1:0]      a,
   output logic [cfm_pkg::WIDE_W-1:0]    sq
);

   logic [cfm_pkg::HALF_W-1:0] a_hi;
   logic [cfm_pkg::HALF_W-1:0] a_lo;
   logic [cfm_pkg::SQ_W-1:0]   hh_in;
   logic [cfm_pkg::SQ_W-1:0]   hl_in;
   logic [cfm_pkg::SQ_W-1:0]   ll_in;
   logic [cfm_pkg::SQ_W-1:0]   hh_ff;
   logic [cfm_pkg::SQ_W-1:0]   hl_ff;
   logic [cfm_pkg::SQ_W-1:0]   ll_ff;
   logic [cfm_pkg::WIDE_W-1:0] sq_in;
   logic [cfm_pkg::WIDE_W-1:0] sq_ff;

   assign a_hi  = a[cfm_pkg::SQ_W-1:cfm_pkg::HALF_W];
   assign a_lo  = a[cfm_pkg::HALF_W-1:0];
   assign hh_in = cfm_pkg::SQ_W'(a_hi) * cfm_pkg::SQ_W'(a_hi);
   assign hl_in = cfm_pkg::SQ_W'(a_hi) * cfm_pkg::SQ_W'(a_lo);
   assign ll_in = cfm_pkg::SQ_W'(a_lo) * cfm_pkg::SQ_W'(a_lo);

   // cross term counts twice: shift by one more than the half width
   assign sq_in = {hh_ff, ll_ff} + (cfm_pkg::WIDE_W'(hl_ff) << (cfm_pkg::HALF_W + 1));

   always_ff @(posedge clock) begin
      if (en.pp) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
      end
      if (en.sum) begin
         sq_ff <= sq_in;
      end
   end

   assign sq = sq_ff;

endmodule

// File: rtl/cfm_div.sv
// ----------------------------------------------------------------------------
// cfm_div: pipelined restoring divider
// One quotient bit per stage of num^2 / den^2, then the final mask select.
// ----------------------------------------------------------------------------
module cfm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cfm_pkg::tag_type              in_tag,
   input  logic [cfm_pkg::WIDE_W-1:0]    in_num2,
   input  logic [cfm_pkg::WIDE_W-1:0]    den2,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cfm_pkg::mask_type             out_mask
);

   localparam int N = cfm_pkg::DIV_STAGES;

   logic [N:1]                 vld_ff;
   logic [N:1]                 vld_in;
   logic [N+1:1]               rdy;
   logic [cfm_pkg::WIDE_W-1:0] rem_ff  [1:N-1];
   logic [cfm_pkg::Q_W-1:0]    q_ff    [1:N-1];
   cfm_pkg::tag_type           tag_ff  [1:N-1];
   logic [cfm_pkg::WIDE_W-1:0] rem_cur [1:N];
   logic [cfm_pkg::Q_W-1:0]    q_cur   [1:N];
   cfm_pkg::tag_type           tag_cur [1:N];
   logic [cfm_pkg::REM_W-1:0]  sh_w    [1:N];
   logic [cfm_pkg::REM_W-1:0]  df_w    [1:N];
   logic [N:1]                 ge;
   logic [cfm_pkg::WIDE_W-1:0] rem_nx  [1:N];
   logic [cfm_pkg::Q_W-1:0]    q_nx    [1:N];
   cfm_pkg::mask_type          mask_in;
   cfm_pkg::mask_type          mask_ff;

   always_comb begin
      rdy[N+1] = out_ready;
      for (int k = N; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign vld_in   = {vld_ff[N-1:1], in_valid};
   assign in_ready = rdy[1];

   always_comb begin
      rem_cur[1] = in_num2;
      q_cur[1]   = '0;
      tag_cur[1] = in_tag;
      for (int j = 2; j <= N; j++) begin
         rem_cur[j] = rem_ff[j-1];
         q_cur[j]   = q_ff[j-1];
         tag_cur[j] = tag_ff[j-1];
      end
      for (int j = 1; j <= N; j++) begin
         sh_w[j]   = {rem_cur[j], 1'b0};
         df_w[j]   = sh_w[j] - {1'b0, den2};
         ge[j]     = (sh_w[j] >= {1'b0, den2});
         rem_nx[j] = ge[j] ? df_w[j][cfm_pkg::WIDE_W-1:0] : sh_w[j][cfm_pkg::WIDE_W-1:0];
         q_nx[j]   = {q_cur[j][cfm_pkg::Q_W-2:0], ge[j]};
      end
      if (tag_cur[N].core) begin
         mask_in = cfm_pkg::MASK_ONE;
      end else if (tag_cur[N].band) begin
         mask_in = {1'b0, q_nx[N]};
      end else begin
         mask_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= N; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 1; j <= N - 1; j++) begin
         if (rdy[j]) begin
            rem_ff[j] <= rem_nx[j];
            q_ff[j]   <= q_nx[j];
            tag_ff[j] <= tag_cur[j];
         end
      end
      if (rdy[N]) begin
         mask_ff <= mask_in;
      end
   end

   assign out_valid = vld_ff[N];
   assign out_mask  = mask_ff;

endmodule

// File: rtl/circle_feather_mask.sv
// ----------------------------------------------------------------------------
// circle_feather_mask: feathered circular mask
// Squared distance of a pixel to a center, mapped to a Q16 opacity with a
// quadratic falloff between the inner and the outer radius.
//
//   channel  dir  handshake          payload
//   req_bus  in   valid/ready        pixel_x, pixel_y
//   rsp_bus  out  valid/ready        mask_value
//   csr_bus  in   valid/ready (=1)   index, data
//
// One pixel per clock sustained while rsp_bus is ready; rsp valid follows the req transaction
// through 23 register stages: seven front stages (input, abs difference, squares,
// sum, compare, two squarer stages) and one divider stage per quotient bit.
// Radius squares and the squared band width are registered after a register write
// and settle before any new item reaches the stage that reads them.
// Reset clears the valid bits and the circle registers; no clearing pass.
// Each stage holds while its successor is full and stalled; bubbles collapse.
// ----------------------------------------------------------------------------
module circle_feather_mask (
   input  logic      clock,
   input  logic      reset,
   cfm_req_if.sink   req_bus,
   cfm_rsp_if.source rsp_bus,
   cfm_csr_if.sink   csr_bus
);

   localparam int NF = 7;

   // configuration
   cfm_pkg::coord_type  center_x_ff;
   cfm_pkg::coord_type  center_y_ff;
   cfm_pkg::radius_type inner_radius_ff;
   cfm_pkg::radius_type outer_radius_ff;
   logic                csr_wr;

   logic [cfm_pkg::SQ_W-1:0]   r2_ff;
   logic [cfm_pkg::SQ_W-1:0]   t2_ff;
   logic [cfm_pkg::SQ_W-1:0]   den_ff;
   logic [cfm_pkg::WIDE_W-1:0] den2;
   cfm_pkg::sqr_en_type        den_en;

   // front pipeline
   logic [NF:1]   vld_ff;
   logic [NF:1]   vld_in;
   logic [NF+1:1] rdy;
   logic          div_in_ready;

   cfm_pkg::coord_type          s1_px_ff;
   cfm_pkg::coord_type          s1_py_ff;
   logic [cfm_pkg::DIFF_W-1:0]  dx_w;
   logic [cfm_pkg::DIFF_W-1:0]  dy_w;
   logic [cfm_pkg::DIFF_W-1:0]  s2_ax_ff;
   logic [cfm_pkg::DIFF_W-1:0]  s2_ay_ff;
   logic [cfm_pkg::D2_W-1:0]    s3_sx_ff;
   logic [cfm_pkg::D2_W-1:0]    s3_sy_ff;
   logic [cfm_pkg::D2_W-1:0]    s4_d2_ff;
   logic [cfm_pkg::SQ_W-1:0]    s5_num_ff;
   cfm_pkg::tag_type            tag_in;
   cfm_pkg::tag_type            tag_ff [5:NF];
   cfm_pkg::sqr_en_type         num_en;
   logic [cfm_pkg::WIDE_W-1:0]  num2;

   // register writes
   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         inner_radius_ff <= '0;
         outer_radius_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_bus.index)
            cfm_pkg::CSR_CENTER_X:     center_x_ff <= csr_bus.data;
            cfm_pkg::CSR_CENTER_Y:     center_y_ff <= csr_bus.data;
            cfm_pkg::CSR_INNER_RADIUS:
               inner_radius_ff <= csr_bus.data[cfm_pkg::RADIUS_W-1:0];
            cfm_pkg::CSR_OUTER_RADIUS:
               outer_radius_ff <= csr_bus.data[cfm_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // derived radius terms
   always_ff @(posedge clock) begin
      r2_ff  <= cfm_pkg::SQ_W'(inner_radius_ff) * cfm_pkg::SQ_W'(inner_radius_ff);
      t2_ff  <= cfm_pkg::SQ_W'(outer_radius_ff) * cfm_pkg::SQ_W'(outer_radius_ff);
      den_ff <= t2_ff - r2_ff;
   end

   assign den_en = '{pp: 1'b1, sum: 1'b1};

   cfm_sqr u_den_sqr (
      .clock (clock),
      .en    (den_en),
      .a     (den_ff),
      .sq    (den2)
   );

   // stage enables
   always_comb begin
      rdy[NF+1] = div_in_ready;
      for (int k = NF; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign vld_in        = {vld_ff[NF-1:1], req_bus.valid};
   assign req_bus.ready = rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NF; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign dx_w = {s1_px_ff[cfm_pkg::COORD_W-1], s1_px_ff}
               - {center_x_ff[cfm_pkg::COORD_W-1], center_x_ff};
   assign dy_w = {s1_py_ff[cfm_pkg::COORD_W-1], s1_py_ff}
               - {center_y_ff[cfm_pkg::COORD_W-1], center_y_ff};

   assign tag_in.core = (s4_d2_ff < cfm_pkg::D2_W'(r2_ff));
   assign tag_in.band = (s4_d2_ff < cfm_pkg::D2_W'(t2_ff));

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_px_ff <= req_bus.pixel_x;
         s1_py_ff <= req_bus.pixel_y;
      end
      if (rdy[2]) begin
         s2_ax_ff <= dx_w[cfm_pkg::DIFF_W-1] ? (~dx_w + 1'b1) : dx_w;
         s2_ay_ff <= dy_w[cfm_pkg::DIFF_W-1] ? (~dy_w + 1'b1) : dy_w;
      end
      if (rdy[3]) begin
         s3_sx_ff <= cfm_pkg::D2_W'(s2_ax_ff) * cfm_pkg::D2_W'(s2_ax_ff);
         s3_sy_ff <= cfm_pkg::D2_W'(s2_ay_ff) * cfm_pkg::D2_W'(s2_ay_ff);
      end
      if (rdy[4]) begin
         s4_d2_ff <= s3_sx_ff + s3_sy_ff;
      end
      if (rdy[5]) begin
         s5_num_ff <= t2_ff - s4_d2_ff[cfm_pkg::SQ_W-1:0];
         tag_ff[5] <= tag_in;
      end
      if (rdy[6]) begin
         tag_ff[6] <= tag_ff[5];
      end
      if (rdy[7]) begin
         tag_ff[7] <= tag_ff[6];
      end
   end

   assign num_en = '{pp: rdy[6], sum: rdy[7]};

   cfm_sqr u_num_sqr (
      .clock (clock),
      .en    (num_en),
      .a     (s5_num_ff),
      .sq    (num2)
   );

   cfm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[NF]),
      .in_ready  (div_in_ready),
      .in_tag    (tag_ff[NF]),
      .in_num2   (num2),
      .den2      (den2),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_mask  (rsp_bus.mask_value)
   );

   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.mask_value <= cfm_pkg::MASK_ONE))
      else $error("mask above unity");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> vld_ff[1])
      else $error("accepted transaction not captured");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NF] && !rdy[NF]) |=> vld_ff[NF])
      else $error("stalled item dropped");

   a_band_nonempty: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[5] && tag_ff[5].band && !tag_ff[5].core) |-> (t2_ff > r2_ff))
      else $error("feather band item with empty band");

endmodule

// File: verif/circle_feather_mask_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_feather_mask_tb: self-checking bench for the feathered circle mask
// Streams pixel coordinates against several circle settings, from the reset
// values through the band edges and an empty band to the widest radii and the
// outermost centers. Each mask response is checked against an exact integer
// prediction of the quadratic falloff. Sender gaps and receiver stalls vary
// per phase, and one long receiver hold fills the pipeline.
// ----------------------------------------------------------------------------
module circle_feather_mask_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int SHOWN_ERRORS = 10;

   localparam cfm_pkg::coord_type  COORD_MAX  = 21'h0FFFFF;
   localparam cfm_pkg::coord_type  COORD_MIN  = 21'h100000;
   localparam cfm_pkg::radius_type RADIUS_MAX = '1;

   logic clock = 1'b0;
   logic reset;

   cfm_req_if req_bus ();
   cfm_rsp_if rsp_bus ();
   cfm_csr_if csr_bus ();

   circle_feather_mask dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // circle settings as last written
   cfm_pkg::coord_type  circle_cx;
   cfm_pkg::coord_type  circle_cy;
   cfm_pkg::radius_type circle_inner;
   cfm_pkg::radius_type circle_outer;

   cfm_pkg::mask_type expected_masks[$];
   int       mask_errors    = 0;
   int       mask_count     = 0;
   int       cycle_count    = 0;
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;
   int       hold_left      = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic cfm_pkg::mask_type predict_mask(input cfm_pkg::coord_type px,
                                                      input cfm_pkg::coord_type py);
      logic signed [cfm_pkg::COORD_W:0] dx, dy;
      logic [cfm_pkg::COORD_W:0]        ax, ay;
      logic [63:0]             d2, r2, t2;
      logic [127:0]            num_sq, den_sq, quot;
      dx = px - circle_cx;
      dy = py - circle_cy;
      ax = dx[cfm_pkg::COORD_W] ? -dx : dx;
      ay = dy[cfm_pkg::COORD_W] ? -dy : dy;
      d2 = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
      r2 = 64'(circle_inner) * 64'(circle_inner);
      t2 = 64'(circle_outer) * 64'(circle_outer);
      if (d2 < r2)
         return cfm_pkg::MASK_ONE;
      if (d2 >= t2)
         return '0;
      num_sq = 128'(t2 - d2) * 128'(t2 - d2);
      den_sq = 128'(t2 - r2) * 128'(t2 - r2);
      quot   = (num_sq << cfm_pkg::Q_W) / den_sq;
      // on the inner edge the quotient saturates at its 16 bits
      if (quot > 128'hFFFF)
         quot = 128'hFFFF;
      return cfm_pkg::mask_type'(quot);
   endfunction

   function automatic cfm_pkg::radius_type pick_radius();
      case ($urandom_range(3))
         0: return cfm_pkg::radius_type'($urandom_range(255));
         1: return cfm_pkg::radius_type'($urandom_range(4095));
         2: return cfm_pkg::radius_type'($urandom_range(65535));
         default: return cfm_pkg::radius_type'($urandom_range(1048575));
      endcase
   endfunction

   // receiver: random stalls, or a counted hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_masks
      cfm_pkg::mask_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_masks.size() == 0) begin
            mask_errors++;
            if (mask_errors <= SHOWN_ERRORS)
               $display("unexpected mask transaction: got %0d", rsp_bus.mask_value);
         end else begin
            want = expected_masks.pop_front();
            if (rsp_bus.mask_value !== want) begin
               mask_errors++;
               if (mask_errors <= SHOWN_ERRORS)
                  $display("mask_value mismatch at transaction %0d: expected %0d, got %0d",
                           mask_count, want, rsp_bus.mask_value);
            end
         end
         mask_count++;
      end
   end

   task automatic send_pixel(input cfm_pkg::coord_type px, input cfm_pkg::coord_type py);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.pixel_x <= px;
      req_bus.pixel_y <= py;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_masks.push_back(predict_mask(px, py));
   endtask

   task automatic send_offset(input int dx, input int dy);
      send_pixel(cfm_pkg::coord_type'(int'(circle_cx) + dx),
                 cfm_pkg::coord_type'(int'(circle_cy) + dy));
   endtask

   task automatic wait_for_masks();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_masks.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input cfm_pkg::csr_idx_type idx,
                            input cfm_pkg::csr_data_type value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         cfm_pkg::CSR_CENTER_X:     circle_cx    = cfm_pkg::coord_type'(value);
         cfm_pkg::CSR_CENTER_Y:     circle_cy    = cfm_pkg::coord_type'(value);
         cfm_pkg::CSR_INNER_RADIUS: circle_inner = value[cfm_pkg::RADIUS_W-1:0];
         cfm_pkg::CSR_OUTER_RADIUS: circle_outer = value[cfm_pkg::RADIUS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // radii go out with a random top bit, which the block must drop
   task automatic program_circle(input cfm_pkg::coord_type cx, input cfm_pkg::coord_type cy,
                                 input cfm_pkg::radius_type ri,
                                 input cfm_pkg::radius_type ro);
      wait_for_masks();
      write_csr(cfm_pkg::CSR_CENTER_X, cfm_pkg::csr_data_type'(cx));
      write_csr(cfm_pkg::CSR_CENTER_Y, cfm_pkg::csr_data_type'(cy));
      write_csr(cfm_pkg::CSR_INNER_RADIUS, {1'($urandom_range(1)), ri});
      write_csr(cfm_pkg::CSR_OUTER_RADIUS, {1'($urandom_range(1)), ro});
   endtask

   task automatic test_reset_state();
      send_pixel('0, '0);
      send_pixel(COORD_MIN, COORD_MIN);
      send_pixel(COORD_MAX, COORD_MAX);
      send_pixel(COORD_MAX, COORD_MIN);
   endtask

   task automatic test_band_edges();
      program_circle(cfm_pkg::coord_type'(-1000), cfm_pkg::coord_type'(2000),
                     20'd100, 20'd200);
      send_offset(0, 0);
      send_offset(99, 0);
      send_offset(100, 0);
      send_offset(60, -80);
      send_offset(0, -150);
      send_offset(199, 0);
      send_offset(120, 160);
      send_offset(-200, 0);
   endtask

   task automatic test_empty_band();
      program_circle(COORD_MAX, COORD_MIN, 20'd200, 20'd100);
      send_offset(0, 0);
      send_offset(-150, 0);
      send_offset(0, 199);
      send_offset(-200, 0);
      program_circle(COORD_MIN, COORD_MAX, 20'd300, 20'd300);
      send_offset(299, 0);
      send_offset(0, -300);
   endtask

   task automatic test_zero_inner();
      program_circle(cfm_pkg::coord_type'(37), cfm_pkg::coord_type'(-5), 20'd0, 20'd64);
      send_offset(0, 0);
      send_offset(63, 0);
      send_offset(0, 64);
   endtask

   task automatic test_ignored_writes();
      wait_for_masks();
      write_csr(cfm_pkg::CSR_INNER_RADIUS, 21'h100000 | 21'd10);
      write_csr(cfm_pkg::CSR_OUTER_RADIUS, 21'h1FFFFF);
      write_csr(cfm_pkg::CSR_OUTER_RADIUS + 8'd1, cfm_pkg::csr_data_type'($urandom));
      write_csr('1, cfm_pkg::csr_data_type'($urandom));
      send_offset(5, 0);
      send_offset(10, 0);
   endtask

   task automatic test_random_circles(input int circles, input int per_circle);
      cfm_pkg::coord_type  cx, cy;
      cfm_pkg::radius_type ri, ro, swap;
      int         span;
      for (int c = 0; c < circles; c++) begin
         cx = cfm_pkg::coord_type'($urandom);
         cy = cfm_pkg::coord_type'($urandom);
         if ($urandom_range(3) == 0)
            cx = $urandom_range(1) ? COORD_MAX : COORD_MIN;
         if ($urandom_range(3) == 0)
            cy = $urandom_range(1) ? COORD_MAX : COORD_MIN;
         ri = pick_radius();
         ro = pick_radius();
         if ($urandom_range(7) == 0)
            ri = '0;
         if ($urandom_range(7) == 0)
            ro = RADIUS_MAX;
         if ($urandom_range(4) != 0 && ro < ri) begin
            swap = ri;
            ri   = ro;
            ro   = swap;
         end
         program_circle(cx, cy, ri, ro);
         span = int'(ro) + int'(ro) / 4 + 16;
         for (int i = 0; i < per_circle; i++) begin
            if ($urandom_range(99) < 75)
               send_offset(int'($urandom_range(2 * span)) - span,
                           int'($urandom_range(2 * span)) - span);
            else
               send_pixel(cfm_pkg::coord_type'($urandom), cfm_pkg::coord_type'($urandom));
         end
      end
   endtask

   task automatic test_backpressure(input int count);
      int span;
      wait_for_masks();
      span = int'(circle_outer) + 16;
      hold_left = HOLD_CYCLES;
      for (int i = 0; i < count; i++)
         send_offset(int'($urandom_range(2 * span)) - span,
                     int'($urandom_range(2 * span)) - span);
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.pixel_x = '0;
      req_bus.pixel_y = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;
      circle_cx       = '0;
      circle_cy       = '0;
      circle_inner    = '0;
      circle_outer    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct  = 33;
      recv_stall_pct = 46;
      test_reset_state();
      test_band_edges();
      test_empty_band();
      test_zero_inner();
      test_ignored_writes();
      test_random_circles(4, 87);

      send_idle_pct  = 46;
      recv_stall_pct = 33;
      test_random_circles(4, 87);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_circles(4, 87);
      test_backpressure(80);

      wait_for_masks();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mask_errors == 0 && expected_masks.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
